### design/blqr_pkg.sv
package blqr_pkg;

   // Fixed-point format of the input items
   localparam int FRAC_BITS = 16;
   localparam int WHEEL_SHIFT = FRAC_BITS + 16;

   // Serial arithmetic unit geometry
   localparam int OPA_W = 48;
   localparam int OPB_W = 34;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int DSR_W = 27;
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(OPB_W);
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(OPA_W);

   // Duty coefficients, Q16
   localparam logic [OPB_W-1:0] C_PITCH = 34'd8468568;
   localparam logic [OPB_W-1:0] C_GYRO = 34'd60609;
   localparam logic [OPB_W-1:0] C_SPEED = 34'd263282098;
   localparam logic [OPB_W-1:0] C_POS = 34'd9170977;
   localparam logic [OPB_W-1:0] C_SINE = 34'd323753;

   // Sine series constants, Q30
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;
   localparam logic [63:0] TERM_LIM = 64'h1000_0000_0000_0000;

   // Sine index rounding: divisor 2 * 360 * 2^16, bias half of it
   localparam logic [DSR_W-1:0] IDX_DIVISOR = 27'd47185920;
   localparam logic [DSR_W-1:0] IDX_BIAS = 27'd23592960;

   // Register indexes
   localparam logic [2:0] CSR_TURN_LINEAR = 3'd0;
   localparam logic [2:0] CSR_TURN_SQUARE = 3'd1;
   localparam logic [2:0] CSR_TURN_DERIV = 3'd2;
   localparam logic [2:0] CSR_TURN_YAW = 3'd3;
   localparam logic [2:0] CSR_LEFT_DEAD_POS = 3'd4;
   localparam logic [2:0] CSR_LEFT_DEAD_NEG = 3'd5;
   localparam logic [2:0] CSR_RIGHT_DEAD_POS = 3'd6;
   localparam logic [2:0] CSR_RIGHT_DEAD_NEG = 3'd7;

   typedef enum logic {
      MODE_MUL,
      MODE_DIV
   } blqr_mode_type;

   typedef struct packed {
      logic          start;
      blqr_mode_type mode;
   } blqr_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IMUL,
      ST_IDIV,
      ST_XMUL,
      ST_XDIV,
      ST_XSQ,
      ST_TMUL,
      ST_TDIV,
      ST_SMUL,
      ST_TERM,
      ST_SQ1,
      ST_SQ2,
      ST_SUM,
      ST_OUT
   } blqr_state_type;

   typedef enum logic [3:0] {
      TERM_PITCH,
      TERM_GYRO,
      TERM_SPEED,
      TERM_POS,
      TERM_SINE,
      TERM_LIN,
      TERM_SQUARE,
      TERM_DER,
      TERM_YAW
   } blqr_term_type;

   // Denominators of the nested sine series
   function automatic logic [OPB_W-1:0] sine_den(input logic [2:0] i);
      logic [OPB_W-1:0] d;
      case (i)
         3'd0: d = 34'd110;
         3'd1: d = 34'd72;
         3'd2: d = 34'd42;
         3'd3: d = 34'd20;
         default: d = 34'd6;
      endcase
      return d;
   endfunction

endpackage

### design/blqr_req_if.sv
interface blqr_req_if;
   logic               valid;
   logic               ready;
   logic signed [24:0] pitch_deg;
   logic signed [24:0] pitch_setpoint_deg;
   logic signed [15:0] gyro_pitch_raw;
   logic signed [15:0] gyro_yaw_raw;
   logic signed [31:0] speed_estimate;
   logic signed [31:0] position_estimate;
   logic signed [31:0] speed_target;
   logic signed [31:0] vision_error;
   logic               hold_drive;

   modport source (
      output valid, pitch_deg, pitch_setpoint_deg, gyro_pitch_raw, gyro_yaw_raw,
             speed_estimate, position_estimate, speed_target, vision_error, hold_drive,
      input  ready
   );
   modport sink (
      input  valid, pitch_deg, pitch_setpoint_deg, gyro_pitch_raw, gyro_yaw_raw,
             speed_estimate, position_estimate, speed_target, vision_error, hold_drive,
      output ready
   );
endinterface

### design/blqr_rsp_if.sv
interface blqr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] left_duty;
   logic signed [14:0] right_duty;
   logic               drive_valid;

   modport source (output valid, left_duty, right_duty, drive_valid, input ready);
   modport sink (input valid, left_duty, right_duty, drive_valid, output ready);
endinterface

### design/blqr_serial_unit.sv
module blqr_serial_unit import blqr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  blqr_op_type       op,
   input  logic [OPA_W-1:0]  opa,
   input  logic [OPB_W-1:0]  opb,
   output logic              done,
   output logic [PROD_W-1:0] result
);

   logic                busy_ff;
   logic                done_ff;
   blqr_mode_type       mode_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [OPA_W-1:0]    opa_ff;
   logic [PROD_W-1:0]   p_ff;
   logic [DSR_W-1:0]    rem_ff;

   logic [OPA_W:0]      mul_sum;
   logic [PROD_W-1:0]   p_mul;
   logic [DSR_W:0]      shifted;
   logic [DSR_W+1:0]    diff;
   logic                ge;
   logic [DSR_W-1:0]    rem_next;
   logic [PROD_W-1:0]   p_div;
   logic                last_step;

   // One multiplier bit: add multiplicand to upper half, shift right
   assign mul_sum = {1'b0, p_ff[PROD_W-1:OPB_W]} + (p_ff[0] ? {1'b0, opa_ff} : '0);
   assign p_mul = {mul_sum, p_ff[OPB_W-1:1]};

   // One quotient bit: restoring trial subtract
   assign shifted = {rem_ff, p_ff[OPA_W-1]};
   assign diff = {1'b0, shifted} - {2'b0, opa_ff[DSR_W-1:0]};
   assign ge = !diff[DSR_W+1];
   assign rem_next = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
   assign p_div = {p_ff[PROD_W-1:OPA_W], p_ff[OPA_W-2:0], ge};

   assign last_step = busy_ff && (cnt_ff == CNT_W'(1));

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step;
         if (op.start) begin
            busy_ff <= 1'b1;
         end else if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Operand and partial result shift registers
   always_ff @(posedge clock) begin
      if (op.start) begin
         mode_ff <= op.mode;
         rem_ff <= '0;
         if (op.mode == MODE_DIV) begin
            cnt_ff <= DIV_STEPS;
            opa_ff <= OPA_W'(opb[DSR_W-1:0]);
            p_ff <= PROD_W'(opa);
         end else begin
            cnt_ff <= MUL_STEPS;
            opa_ff <= opa;
            p_ff <= PROD_W'(opb);
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (mode_ff == MODE_DIV) begin
            p_ff <= p_div;
            rem_ff <= rem_next;
         end else begin
            p_ff <= p_mul;
         end
      end
   end

   assign done = done_ff;
   assign result = p_ff;

endmodule

### design/blqr_wheel.sv
module blqr_wheel import blqr_pkg::*; #(
   parameter int LIMIT = 10000
) (
   input  logic signed [63:0] sum,
   input  logic [11:0]        dead_pos,
   input  logic signed [12:0] dead_neg,
   output logic signed [14:0] duty
);

   localparam int LIM = (LIMIT < 16383) ? LIMIT : 16383;
   localparam logic signed [16:0] LIM_S = 17'(LIM);
   localparam logic signed [63:0] TRUNC_BIAS = 64'((64'd1 << WHEEL_SHIFT) - 64'd1);

   logic signed [63:0] biased;
   logic signed [31:0] whole;
   logic signed [15:0] sat;
   logic signed [16:0] off;

   // Truncate toward zero, saturate to 16 bits, add dead-zone offset, clamp
   always_comb begin
      biased = sum + (sum[63] ? TRUNC_BIAS : 64'sd0);
      whole = 32'(biased >>> WHEEL_SHIFT);
      if (whole > 32'sd32767) begin
         sat = 16'sd32767;
      end else if (whole < -32'sd32768) begin
         sat = -16'sd32768;
      end else begin
         sat = 16'(whole);
      end
      if (sat > 16'sd0) begin
         off = 17'(sat) + $signed({5'b0, dead_pos});
      end else begin
         off = 17'(sat) + 17'(dead_neg);
      end
      if (sat == 16'sd0) begin
         duty = 15'sd0;
      end else if (off > LIM_S) begin
         duty = 15'(LIM_S);
      end else if (off < -LIM_S) begin
         duty = 15'(-LIM_S);
      end else begin
         duty = 15'(off);
      end
   end

endmodule

### design/balance_lqr_turn_controller_core.sv
// All arithmetic runs one bit per cycle through a single shared shift-add
// multiplier / restoring divider (19 multiplies and 7 divides per item); a new
// item is accepted only once the previous one has left the output state.
// Reset (synchronous, active high) restores the register defaults, clears the
// previous position and vision error and empties the result register.
module balance_lqr_turn_controller_core import blqr_pkg::*; #(
   parameter int DUTY_LIMIT = 10000,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   blqr_req_if.sink    req_chan,
   blqr_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int IW = $clog2(SINE_TABLE_DEPTH);
   localparam int KW = IW + 3;
   localparam logic [KW-1:0] DEPTH_K = KW'(SINE_TABLE_DEPTH);
   localparam int LIM = (DUTY_LIMIT < 16383) ? DUTY_LIMIT : 16383;

   // Configuration registers
   logic [23:0]        gain_lin_ff, gain_sq_ff, gain_der_ff, gain_yaw_ff;
   logic [11:0]        ldp_ff, rdp_ff;
   logic signed [12:0] ldn_ff, rdn_ff;

   // Item and state registers
   logic signed [24:0] pitch_ff, setp_ff;
   logic signed [15:0] gy_ff, gz_ff;
   logic signed [31:0] v_ff, x_ff_in_pos, vt_ff, e_ff;
   logic               hold_ff;
   logic signed [31:0] prev_pos_ff, prev_err_ff;

   // Sequencer
   blqr_state_type     state_ff, state_in;
   logic               launched_ff;
   blqr_term_type      term_ff;
   logic [2:0]         iter_ff;

   // Working registers
   logic               sign_ff;
   logic [OPA_W-1:0]   num_ff;
   logic [IW-1:0]      k_ff;
   logic [31:0]        x_ff;
   logic [32:0]        x2_ff;
   logic [30:0]        t_ff;
   logic signed [17:0] sn_ff;
   logic [46:0]        q_ff;
   logic signed [63:0] torque_ff, steer_ff;
   logic signed [63:0] lsum_ff, rsum_ff;

   // Result register
   logic               rsp_valid_ff;
   logic signed [14:0] left_ff, right_ff;
   logic               drv_ff;

   // Unit connection
   blqr_op_type        op;
   logic [OPA_W-1:0]   opa;
   logic [OPB_W-1:0]   opb;
   logic               unit_done;
   logic [PROD_W-1:0]  prod;

   logic               accept;
   logic               rsp_free;
   logic               op_state;

   // Sine fold and term operands
   logic [KW-1:0]      k_ext, kf, kf2, kf4, fold_a;
   logic               fold_neg;
   logic signed [33:0] term_a;
   logic [33:0]        term_mag;
   logic               term_neg;
   logic [OPB_W-1:0]   term_c;
   logic               term_sub, term_shift;
   logic signed [63:0] term_val;

   // Capture helpers
   logic signed [40:0] idx_num;
   logic signed [IW+1:0] idx_s;
   logic [32:0]        s_round;
   logic [18:0]        r_mag;
   logic [63:0]        sq_mag;
   logic signed [14:0] left_duty, right_duty;

   assign accept = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.left_duty = left_ff;
   assign rsp_chan.right_duty = right_ff;
   assign rsp_chan.drive_valid = drv_ff;

   blqr_serial_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .opa    (opa),
      .opb    (opb),
      .done   (unit_done),
      .result (prod)
   );

   blqr_wheel #(.LIMIT(DUTY_LIMIT)) u_left (
      .sum      (lsum_ff),
      .dead_pos (ldp_ff),
      .dead_neg (ldn_ff),
      .duty     (left_duty)
   );

   blqr_wheel #(.LIMIT(DUTY_LIMIT)) u_right (
      .sum      (rsum_ff),
      .dead_pos (rdp_ff),
      .dead_neg (rdn_ff),
      .duty     (right_duty)
   );

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_lin_ff <= 24'd2309489;
         gain_sq_ff <= 24'd39977;
         gain_der_ff <= 24'd49152;
         gain_yaw_ff <= 24'd32113;
         ldp_ff <= '0;
         ldn_ff <= '0;
         rdp_ff <= '0;
         rdn_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TURN_LINEAR:    gain_lin_ff <= csr_wdata;
            CSR_TURN_SQUARE:    gain_sq_ff <= csr_wdata;
            CSR_TURN_DERIV:     gain_der_ff <= csr_wdata;
            CSR_TURN_YAW:       gain_yaw_ff <= csr_wdata;
            CSR_LEFT_DEAD_POS:  ldp_ff <= csr_wdata[11:0];
            CSR_LEFT_DEAD_NEG:  ldn_ff <= $signed(csr_wdata[12:0]);
            CSR_RIGHT_DEAD_POS: rdp_ff <= csr_wdata[11:0];
            CSR_RIGHT_DEAD_NEG: rdn_ff <= $signed(csr_wdata[12:0]);
            default: ;
         endcase
      end
   end

   // Sine quadrant fold of the table index
   always_comb begin
      k_ext = KW'(k_ff);
      fold_neg = (k_ext << 1) > DEPTH_K;
      kf = fold_neg ? (DEPTH_K - k_ext) : k_ext;
      kf2 = kf << 1;
      kf4 = kf << 2;
      fold_a = (kf4 > DEPTH_K) ? (DEPTH_K - kf2) : kf2;
   end

   // LQR and steering term selection
   always_comb begin
      term_sub = 1'b0;
      term_shift = 1'b0;
      case (term_ff)
         TERM_PITCH: begin
            term_a = 34'(pitch_ff) - 34'(setp_ff);
            term_c = C_PITCH;
         end
         TERM_GYRO: begin
            term_a = 34'(gy_ff);
            term_c = C_GYRO;
            term_shift = 1'b1;
         end
         TERM_SPEED: begin
            term_a = 34'(v_ff) - 34'(vt_ff);
            term_c = C_SPEED;
            term_sub = 1'b1;
         end
         TERM_POS: begin
            term_a = 34'(x_ff_in_pos) - 34'(prev_pos_ff) - 34'(v_ff);
            term_c = C_POS;
            term_sub = 1'b1;
         end
         TERM_SINE: begin
            term_a = 34'(sn_ff);
            term_c = C_SINE;
            term_sub = 1'b1;
         end
         TERM_LIN: begin
            term_a = 34'(e_ff);
            term_c = OPB_W'(gain_lin_ff);
         end
         TERM_DER: begin
            term_a = 34'(e_ff) - 34'(prev_err_ff);
            term_c = OPB_W'(gain_der_ff);
         end
         TERM_YAW: begin
            term_a = 34'(gz_ff);
            term_c = OPB_W'(gain_yaw_ff);
            term_shift = 1'b1;
            term_sub = 1'b1;
         end
         default: begin
            term_a = 34'(e_ff);
            term_c = OPB_W'(gain_sq_ff);
         end
      endcase
      term_neg = term_a[33];
      term_mag = term_neg ? 34'(-term_a) : 34'(term_a);
      term_val = term_shift ? $signed({prod[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}})
                            : $signed(prod[63:0]);
      if (term_neg ^ term_sub) begin
         term_val = -term_val;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_IMUL;
         ST_IMUL: if (unit_done) state_in = ST_IDIV;
         ST_IDIV: if (unit_done) state_in = ST_XMUL;
         ST_XMUL: if (unit_done) state_in = ST_XDIV;
         ST_XDIV: if (unit_done) state_in = ST_XSQ;
         ST_XSQ:  if (unit_done) state_in = ST_TMUL;
         ST_TMUL: if (unit_done) state_in = ST_TDIV;
         ST_TDIV: begin
            if (unit_done) state_in = (iter_ff == 3'd4) ? ST_SMUL : ST_TMUL;
         end
         ST_SMUL: if (unit_done) state_in = ST_TERM;
         ST_TERM: begin
            if (unit_done) begin
               if (term_ff == TERM_LIN) begin
                  state_in = ST_SQ1;
               end else if (term_ff == TERM_YAW) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SQ1:  if (unit_done) state_in = ST_SQ2;
         ST_SQ2:  if (unit_done) state_in = ST_TERM;
         ST_SUM:  state_in = ST_OUT;
         ST_OUT:  if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Unit operation per state
   always_comb begin
      op_state = 1'b1;
      op.mode = MODE_MUL;
      opa = '0;
      opb = '0;
      unique case (state_ff)
         ST_IMUL: begin
            opa = OPA_W'($unsigned(pitch_ff[24] ? -pitch_ff : pitch_ff));
            opb = OPB_W'(2 * SINE_TABLE_DEPTH);
         end
         ST_IDIV: begin
            op.mode = MODE_DIV;
            opa = num_ff;
            opb = OPB_W'(IDX_DIVISOR);
         end
         ST_XMUL: begin
            opa = OPA_W'(PI_Q30);
            opb = OPB_W'(fold_a);
         end
         ST_XDIV: begin
            op.mode = MODE_DIV;
            opa = num_ff;
            opb = OPB_W'(SINE_TABLE_DEPTH);
         end
         ST_XSQ: begin
            opa = OPA_W'(x_ff);
            opb = OPB_W'(x_ff);
         end
         ST_TMUL: begin
            opa = OPA_W'(x2_ff);
            opb = OPB_W'(t_ff);
         end
         ST_TDIV: begin
            op.mode = MODE_DIV;
            opa = num_ff;
            opb = sine_den(iter_ff);
         end
         ST_SMUL: begin
            opa = OPA_W'(x_ff);
            opb = OPB_W'(t_ff);
         end
         ST_TERM: begin
            opa = OPA_W'(term_mag);
            opb = term_c;
         end
         ST_SQ1: begin
            opa = OPA_W'(term_mag);
            opb = term_mag;
         end
         ST_SQ2: begin
            opa = OPA_W'(q_ff);
            opb = OPB_W'(gain_sq_ff);
         end
         default: op_state = 1'b0;
      endcase
      op.start = op_state && !launched_ff;
   end

   // Capture helpers for the index and the sine result
   always_comb begin
      idx_num = (pitch_ff[24] ? -41'(prod[39:0]) : 41'(prod[39:0])) + 41'(IDX_BIAS);
      idx_s = sign_ff ? -(IW+2)'(prod[IW:0]) : (IW+2)'(prod[IW:0]);
      if (idx_s < 0) begin
         idx_s = idx_s + (IW+2)'(SINE_TABLE_DEPTH);
      end else if (idx_s >= (IW+2)'(SINE_TABLE_DEPTH)) begin
         idx_s = idx_s - (IW+2)'(SINE_TABLE_DEPTH);
      end
      s_round = {1'b0, prod[61:30]} + 33'(1 << (29 - FRAC_BITS));
      r_mag = 19'(s_round >> (30 - FRAC_BITS));
      if (r_mag > 19'(1 << FRAC_BITS)) begin
         r_mag = 19'(1 << FRAC_BITS);
      end
      sq_mag = (prod > PROD_W'(TERM_LIM)) ? TERM_LIM : prod[63:0];
   end

   // Sequencer control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         launched_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_pos_ff <= '0;
         prev_err_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (op.start) begin
            launched_ff <= 1'b1;
         end else if (unit_done) begin
            launched_ff <= 1'b0;
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            prev_pos_ff <= x_ff_in_pos;
            prev_err_ff <= e_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pitch_ff <= req_chan.pitch_deg;
         setp_ff <= req_chan.pitch_setpoint_deg;
         gy_ff <= req_chan.gyro_pitch_raw;
         gz_ff <= req_chan.gyro_yaw_raw;
         v_ff <= req_chan.speed_estimate;
         x_ff_in_pos <= req_chan.position_estimate;
         vt_ff <= req_chan.speed_target;
         e_ff <= req_chan.vision_error;
         hold_ff <= req_chan.hold_drive;
         torque_ff <= '0;
         steer_ff <= '0;
         term_ff <= TERM_PITCH;
         iter_ff <= '0;
      end
      if (unit_done) begin
         case (state_ff)
            ST_IMUL: begin
               sign_ff <= idx_num[40];
               num_ff <= idx_num[40] ? OPA_W'(-idx_num) + OPA_W'(IDX_DIVISOR - 27'd1)
                                     : OPA_W'(idx_num);
            end
            ST_IDIV: k_ff <= IW'(idx_s);
            ST_XMUL: num_ff <= prod[OPA_W-1:0] + OPA_W'(SINE_TABLE_DEPTH / 2);
            ST_XDIV: x_ff <= prod[31:0];
            ST_XSQ: begin
               x2_ff <= 33'((prod[63:0] + 64'(ONE_Q30 >> 1)) >> 30);
               t_ff <= ONE_Q30;
               iter_ff <= '0;
            end
            ST_TMUL: num_ff <= OPA_W'(prod[63:30]);
            ST_TDIV: begin
               t_ff <= ONE_Q30 - prod[30:0];
               iter_ff <= iter_ff + 3'd1;
            end
            ST_SMUL: sn_ff <= fold_neg ? -18'(r_mag) : 18'(r_mag);
            ST_TERM: begin
               if (term_ff == TERM_LIN || term_ff == TERM_DER || term_ff == TERM_YAW) begin
                  steer_ff <= steer_ff + term_val;
               end else begin
                  torque_ff <= torque_ff + term_val;
               end
               if (term_ff != TERM_YAW) begin
                  term_ff <= blqr_term_type'(term_ff + 4'd1);
               end
            end
            ST_SQ1: q_ff <= prod[46+FRAC_BITS:FRAC_BITS];
            ST_SQ2: begin
               steer_ff <= steer_ff + (term_neg ? -$signed(sq_mag) : $signed(sq_mag));
               term_ff <= TERM_DER;
            end
            default: ;
         endcase
      end
      if (state_ff == ST_SUM) begin
         lsum_ff <= torque_ff - steer_ff;
         rsum_ff <= torque_ff + steer_ff;
      end
      if (state_ff == ST_OUT && rsp_free) begin
         left_ff <= left_duty;
         right_ff <= 15'(-right_duty);
         drv_ff <= !hold_ff;
      end
   end

`ifndef SYNTHESIS
   a_done_launched: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> launched_ff)
      else $error("unit finished with no operation launched");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_IMUL)
      else $error("accepted item did not start the index multiply");
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not registered on leaving output state");
   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM) |-> (sn_ff <= 18'sd65536 && sn_ff >= -18'sd65536))
      else $error("sine value out of range");
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (left_ff <= 15'(LIM) && left_ff >= -15'(LIM)
                        && right_ff <= 15'(LIM) && right_ff >= -15'(LIM)))
      else $error("duty beyond limit");
`endif

endmodule

### dv/tb_balance_lqr_turn_controller_core.sv
`timescale 1ns / 100ps

module tb_balance_lqr_turn_controller_core import blqr_pkg::*;;

   localparam int DUTY_MAX = 10000;
   localparam int SINE_DEPTH = 1024;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 1200;

   typedef struct {
      logic signed [24:0] pitch;
      logic signed [24:0] setpoint;
      logic signed [15:0] gyro_pitch;
      logic signed [15:0] gyro_yaw;
      logic signed [31:0] speed;
      logic signed [31:0] position;
      logic signed [31:0] speed_tgt;
      logic signed [31:0] line_err;
      logic               hold;
   } tick_type;

   typedef struct {
      logic signed [14:0] left;
      logic signed [14:0] right;
      logic               drive;
   } duty_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   blqr_req_if req ();
   blqr_rsp_if rsp ();

   balance_lqr_turn_controller_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req.sink),
      .rsp_chan  (rsp.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor copy of registers and state
   logic [23:0] gain_lin, gain_sq, gain_der, gain_yaw;
   logic [11:0] ldead_pos, rdead_pos;
   logic signed [12:0] ldead_neg, rdead_neg;
   longint last_position, last_line_err;

   duty_type expected_duties[$];
   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic longint scale_sat(input longint p, input int sh);
      longint lim;
      lim = longint'(TERM_LIM) >>> sh;
      if (p > lim) return longint'(TERM_LIM);
      if (p < -lim) return -longint'(TERM_LIM);
      return p * (longint'(1) << sh);
   endfunction

   function automatic longint trunc_shift(input longint v, input int sh);
      return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // sine of table index k, Q16, by the nested series
   function automatic longint sine_lookup(input longint k);
      longint unsigned dens[5];
      longint unsigned a, x, x2, t, s, r;
      longint n;
      bit neg;
      dens = '{110, 72, 42, 20, 6};
      n = SINE_DEPTH;
      neg = 0;
      if (2 * k > n) begin
         k = n - k;
         neg = 1;
      end
      a = (4 * k > n) ? longint'(n - 2 * k) : longint'(2 * k);
      x = (longint'(PI_Q30) * a + n / 2) / n;
      x2 = (x * x + (longint'(ONE_Q30) >> 1)) >> 30;
      t = 64'(ONE_Q30);
      for (int i = 0; i < 5; i++)
         t = longint'(ONE_Q30) - (((x2 * t) >> 30) / dens[i]);
      s = (x * t) >> 30;
      r = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (r > (64'd1 << FRAC_BITS)) r = 64'd1 << FRAC_BITS;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint dead_zone(input longint d, input longint pos, input longint negv);
      if (d > 0) return clip(d + pos, -DUTY_MAX, DUTY_MAX);
      if (d < 0) return clip(d + negv, -DUTY_MAX, DUTY_MAX);
      return 0;
   endfunction

   // one control tick: duties and state update
   function automatic duty_type predict_duties(input tick_type t);
      duty_type res;
      longint pitch, e, denom, n, idx, sn, torque, steer, sq, lo, ro, ld, rd;
      longint unsigned mag, q;
      pitch = longint'(t.pitch);
      e = longint'(t.line_err);
      denom = longint'(360) << FRAC_BITS;
      n = 2 * pitch * SINE_DEPTH + denom;
      idx = (n >= 0) ? n / (2 * denom) : -((-n + 2 * denom - 1) / (2 * denom));
      idx = idx % SINE_DEPTH;
      if (idx < 0) idx += SINE_DEPTH;
      sn = sine_lookup(idx);

      torque = longint'(C_PITCH) * (pitch - longint'(t.setpoint))
             + scale_sat(longint'(C_GYRO) * longint'(t.gyro_pitch), FRAC_BITS)
             - longint'(C_SPEED) * (longint'(t.speed) - longint'(t.speed_tgt))
             - longint'(C_POS) * (longint'(t.position) - last_position - longint'(t.speed))
             - longint'(C_SINE) * sn;

      mag = (e < 0) ? -e : e;
      q = (mag * mag) >> FRAC_BITS;
      if (gain_sq != 0 && q > longint'(TERM_LIM) / longint'(gain_sq))
         sq = longint'(TERM_LIM);
      else
         sq = q * longint'(gain_sq);
      if (e < 0) sq = -sq;

      steer = longint'(gain_lin) * e + sq
            + longint'(gain_der) * (e - last_line_err)
            - scale_sat(longint'(t.gyro_yaw) * longint'(gain_yaw), FRAC_BITS);

      last_position = longint'(t.position);
      last_line_err = e;

      lo = clip(trunc_shift(torque - steer, WHEEL_SHIFT), -32768, 32767);
      ro = clip(trunc_shift(torque + steer, WHEEL_SHIFT), -32768, 32767);
      ld = dead_zone(lo, ldead_pos, ldead_neg);
      rd = dead_zone(ro, rdead_pos, rdead_neg);
      res.left = ld[14:0];
      res.right = 15'(-rd);
      res.drive = !t.hold;
      return res;
   endfunction

   function automatic void predictor_reset();
      gain_lin = 24'd2309489;
      gain_sq = 24'd39977;
      gain_der = 24'd49152;
      gain_yaw = 24'd32113;
      ldead_pos = '0;
      rdead_pos = '0;
      ldead_neg = '0;
      rdead_neg = '0;
      last_position = 0;
      last_line_err = 0;
   endfunction

   // register write, enable left high for the caller to lower
   task automatic csr_write(input logic [2:0] idx, input logic [23:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TURN_LINEAR:    gain_lin = val;
         CSR_TURN_SQUARE:    gain_sq = val;
         CSR_TURN_DERIV:     gain_der = val;
         CSR_TURN_YAW:       gain_yaw = val;
         CSR_LEFT_DEAD_POS:  ldead_pos = val[11:0];
         CSR_LEFT_DEAD_NEG:  ldead_neg = val[12:0];
         CSR_RIGHT_DEAD_POS: rdead_pos = val[11:0];
         default:            rdead_neg = val[12:0];
      endcase
      @(posedge clock);
   endtask

   // wait for the block to go idle, then load all registers
   task automatic load_registers(input logic [23:0] lin, sq, der, yaw,
                                 input logic [23:0] lpos, lneg, rpos, rneg);
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_write(CSR_TURN_LINEAR, lin);
      csr_write(CSR_TURN_SQUARE, sq);
      csr_write(CSR_TURN_DERIV, der);
      csr_write(CSR_TURN_YAW, yaw);
      csr_write(CSR_LEFT_DEAD_POS, lpos);
      csr_write(CSR_LEFT_DEAD_NEG, lneg);
      csr_write(CSR_RIGHT_DEAD_POS, rpos);
      csr_write(CSR_RIGHT_DEAD_NEG, rneg);
      csr_wr_en <= 1'b0;
   endtask

   // send one tick; valid stays high afterwards
   task automatic send_tick(input tick_type t);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pitch_deg <= t.pitch;
      req.pitch_setpoint_deg <= t.setpoint;
      req.gyro_pitch_raw <= t.gyro_pitch;
      req.gyro_yaw_raw <= t.gyro_yaw;
      req.speed_estimate <= t.speed;
      req.position_estimate <= t.position;
      req.speed_target <= t.speed_tgt;
      req.vision_error <= t.line_err;
      req.hold_drive <= t.hold;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_duties.push_back(predict_duties(t));
   endtask

   function automatic logic signed [24:0] any_angle();
      return 25'($signed($urandom_range(23592960)) - 32'sd11796480);
   endfunction

   // random tick: mostly a plausible balancing state, sometimes full range
   function automatic tick_type random_tick();
      tick_type t;
      t.hold = ($urandom_range(9) == 0);
      if ($urandom_range(99) < 60) begin
         t.pitch = 25'($signed($urandom_range(3932160)) - 32'sd1966080);
         t.setpoint = 25'($signed($urandom_range(393216)) - 32'sd196608);
         t.gyro_pitch = 16'($signed($urandom_range(8000)) - 32'sd4000);
         t.gyro_yaw = 16'($signed($urandom_range(8000)) - 32'sd4000);
         t.speed = $signed($urandom_range(655360)) - 32'sd327680;
         t.speed_tgt = $signed($urandom_range(655360)) - 32'sd327680;
         t.position = 32'(last_position + longint'(t.speed)
                      + longint'($urandom_range(65536)) - 32768);
         t.line_err = $signed($urandom_range(8388608)) - 32'sd4194304;
      end else begin
         t.pitch = any_angle();
         t.setpoint = any_angle();
         t.gyro_pitch = 16'($urandom);
         t.gyro_yaw = 16'($urandom);
         t.speed = $urandom;
         t.speed_tgt = $urandom;
         t.position = $urandom;
         t.line_err = $urandom;
      end
      return t;
   endfunction

   function automatic tick_type make_tick(input longint p, sp, gp, gz, v, x, vt, e,
                                          input logic h);
      tick_type t;
      t.pitch = 25'(p);
      t.setpoint = 25'(sp);
      t.gyro_pitch = 16'(gp);
      t.gyro_yaw = 16'(gz);
      t.speed = 32'(v);
      t.position = 32'(x);
      t.speed_tgt = 32'(vt);
      t.line_err = 32'(e);
      t.hold = h;
      return t;
   endfunction

   // result checking, receiver stalls and watchdog
   always @(posedge clock) begin
      duty_type exp_d;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp.valid && rsp.ready) begin
            if (expected_duties.size() == 0) begin
               report_mismatch("result item with nothing expected");
            end else begin
               exp_d = expected_duties.pop_front();
               if (rsp.left_duty !== exp_d.left)
                  report_mismatch($sformatf("left_duty %0d, expected %0d",
                                  rsp.left_duty, exp_d.left));
               if (rsp.right_duty !== exp_d.right)
                  report_mismatch($sformatf("right_duty %0d, expected %0d",
                                  rsp.right_duty, exp_d.right));
               if (rsp.drive_valid !== exp_d.drive)
                  report_mismatch($sformatf("drive_valid %0b, expected %0b",
                                  rsp.drive_valid, exp_d.drive));
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // extremes of every field, sine wrap points, hold flag
   task automatic test_directed_extremes();
      tick_type list[$];
      list.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_tick(11796480, -11796480, 32767, -32768,
                               32'sh7fffffff, 32'sh7fffffff, -32'sh80000000,
                               32'sh7fffffff, 0));
      list.push_back(make_tick(-11796480, 11796480, -32768, 32767,
                               -32'sh80000000, -32'sh80000000, 32'sh7fffffff,
                               -32'sh80000000, 1));
      list.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, -32'sh80000000, 0));
      list.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 32'sh7fffffff, 1));
      // 90 and -90 degrees, peaks of the sine
      list.push_back(make_tick(5898240, 5898240, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_tick(-5898240, -5898240, 0, 0, 0, 0, 0, 0, 0));
      // rounding tie of the sine index and just below it
      list.push_back(make_tick(11520, 0, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_tick(11519, 0, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_tick(-11520, 0, 0, 0, 0, 0, 0, 0, 0));
      // near 180 degrees, index reaches half the table depth
      list.push_back(make_tick(11790000, 11790000, 0, 0, 0, 0, 0, 0, 0));
      // small duties: zero and near-zero, dead zone sign handling
      list.push_back(make_tick(1000, 0, 10, 0, 0, 0, 0, 0, 0));
      list.push_back(make_tick(-1000, 0, -10, 0, 0, 0, 0, 0, 0));
      list.push_back(make_tick(0, 0, 1, 0, 0, 0, 0, 0, 1));
      list.push_back(make_tick(0, 0, 0, 32767, 0, 0, 0, 0, 0));
      list.push_back(make_tick(0, 0, 0, -32768, 0, 0, 0, 65536, 0));
      list.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, -65536, 0));
      foreach (list[i]) send_tick(list[i]);
   endtask

   task automatic test_random_ticks(input int count);
      repeat (count) send_tick(random_tick());
   endtask

   task automatic test_gain_extremes();
      load_registers(24'd0, 24'd0, 24'd0, 24'd0, 24'd4000, -24'sd4000, 24'd4000, -24'sd4000);
      test_directed_extremes();
      test_random_ticks(40);
      load_registers(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                     24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
      test_directed_extremes();
      test_random_ticks(40);
   endtask

   task automatic test_dead_zones_random();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         load_registers(24'($urandom_range(4000000)), 24'($urandom_range(200000)),
                        24'($urandom_range(200000)), 24'($urandom_range(100000)),
                        24'($urandom_range(4000)), 24'(-$urandom_range(4000)),
                        24'($urandom_range(4000)), 24'(-$urandom_range(4000)));
         test_random_ticks(130);
      end
   endtask

   initial begin
      predictor_reset();
      req.valid = 1'b0;
      req.pitch_deg = '0;
      req.pitch_setpoint_deg = '0;
      req.gyro_pitch_raw = '0;
      req.gyro_yaw_raw = '0;
      req.speed_estimate = '0;
      req.position_estimate = '0;
      req.speed_target = '0;
      req.vision_error = '0;
      req.hold_drive = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_random_ticks(40);
      test_gain_extremes();
      test_dead_zones_random();

      req.valid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
design/blqr_pkg.sv
design/blqr_req_if.sv
design/blqr_rsp_if.sv
design/blqr_serial_unit.sv
design/blqr_wheel.sv
design/balance_lqr_turn_controller_core.sv
dv/tb_balance_lqr_turn_controller_core.sv
